// ===== rtl/wpm_pkg.sv =====
`default_nettype none

package wpm_pkg;

	// Pattern store capacity and the widths that follow from it.
	localparam int PATTERN_DEPTH = 32;
	localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);
	localparam int IDX_W         = $clog2(PATTERN_DEPTH);

	// Wildcard bytes.
	localparam logic [7:0] SYM_STAR = 8'h2A;
	localparam logic [7:0] SYM_ANY  = 8'h3F;

	// Input transaction kinds.
	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_TEXT   = 2'd2,
		ACT_END    = 2'd3
	} action_t;

endpackage

`default_nettype wire

// ===== rtl/wildcard_pattern_matcher_top.sv =====
// Whole-string wildcard matcher ('*' matches any run, '?' any single byte).
// Input channel: in_valid / in_stall with fields action and symbol. Action
// clear empties the pattern, append adds one pattern byte, text feeds one
// text byte and end closes the text. Only an end transaction produces a
// result on the output channel (out_valid / out_stall, fields matched and
// overflow); all other transactions produce none.
// An end transaction passes through the input register and then the output
// register. Throughput is one transaction per cycle while in_stall is low;
// the set of reachable pattern positions is updated by one combinational
// stage of per-position compares plus a one-step star closure (repeated
// stars are collapsed on entry, so a closure spans at most one position).
// When the receiver stalls, the result holds in the output register and
// pattern and text transactions keep flowing; only a second end transaction
// waits in the input register, which raises in_stall.
// Reset empties the pattern, clears the overflow flag and both pipeline
// valids. A pattern byte (not a repeated star) appended to a full store is
// dropped and sets a sticky overflow flag, cleared only by clear or reset.
`default_nettype none

module wildcard_pattern_matcher_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] action,
	input  wire logic [7:0] symbol,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            matched,
	output logic            overflow
);

	localparam int D = wpm_pkg::PATTERN_DEPTH;

	// Input register.
	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] symbol_s1;

	// Pattern state.
	logic [7:0]                 store_q [D];
	logic [D-1:0]               star_q;
	logic [D-1:0]               any_q;
	logic [D-1:0]               live_q;
	logic [wpm_pkg::LEN_W-1:0]  len_q;
	logic                       last_star_q;
	logic                       ovf_q;
	logic [D:0]                 reach_q;

	// Output register.
	logic out_valid_q;
	logic matched_q;
	logic overflow_q;

	logic                       out_free;
	logic                       adv_s1;
	logic                       fire_s1;
	logic [D-1:0]               hit;
	logic [D:0]                 reach_step;
	logic [D:0]                 reach_text;
	logic [D:0]                 reach_append;
	logic [D:0]                 reach_end;
	logic                       star0_new;
	logic                       sym_is_star;
	logic                       drop_star;
	logic                       store_full;
	logic [wpm_pkg::IDX_W-1:0]  wr_idx;

	// Handshake: only an end transaction needs the output slot.
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = (action_s1 != wpm_pkg::ACT_END) || out_free;
	assign fire_s1  = valid_s1 && adv_s1;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			symbol_s1 <= symbol;
		end
	end

	// Append decisions.
	assign sym_is_star = (symbol_s1 == wpm_pkg::SYM_STAR);
	assign drop_star   = sym_is_star && last_star_q;
	assign store_full  = (len_q == wpm_pkg::LEN_W'(D));
	assign wr_idx      = len_q[wpm_pkg::IDX_W-1:0];
	assign star0_new   = (len_q == '0) ? sym_is_star : star_q[0];

	// Text byte: advance every live position, then close over single stars.
	always_comb begin
		for (int p = 0; p < D; p++) begin
			hit[p] = reach_q[p] && live_q[p] && !star_q[p] &&
				(any_q[p] || (store_q[p] == symbol_s1));
		end
		reach_step = (reach_q & {1'b0, star_q}) | {hit, 1'b0};
		reach_text = reach_step | {(reach_step[D-1:0] & star_q), 1'b0};
	end

	// Restart sets: closure of position zero for the new or current pattern.
	assign reach_append = (D+1)'(1) | ((D+1)'(star0_new) << 1);
	assign reach_end    = (D+1)'(1) | ((D+1)'(star_q[0]) << 1);

	// Control and per-position flags of the pattern.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_q      <= '0;
			any_q       <= '0;
			live_q      <= '0;
			len_q       <= '0;
			last_star_q <= 1'b0;
			ovf_q       <= 1'b0;
			reach_q     <= (D+1)'(1);
		end else if (fire_s1) begin
			case (action_s1)
				wpm_pkg::ACT_CLEAR: begin
					star_q      <= '0;
					any_q       <= '0;
					live_q      <= '0;
					len_q       <= '0;
					last_star_q <= 1'b0;
					ovf_q       <= 1'b0;
					reach_q     <= (D+1)'(1);
				end
				wpm_pkg::ACT_APPEND: begin
					if (drop_star) begin
						// A repeated star changes nothing.
					end else if (store_full) begin
						ovf_q <= 1'b1;
					end else begin
						star_q[wr_idx] <= sym_is_star;
						any_q[wr_idx]  <= (symbol_s1 == wpm_pkg::SYM_ANY);
						live_q[wr_idx] <= 1'b1;
						len_q          <= len_q + 1'b1;
						last_star_q    <= sym_is_star;
						reach_q        <= reach_append;
					end
				end
				wpm_pkg::ACT_TEXT: begin
					reach_q <= reach_text;
				end
				default: begin
					reach_q <= reach_end;
				end
			endcase
		end
	end

	// Pattern byte store.
	always_ff @(posedge clk) begin
		if (fire_s1 && (action_s1 == wpm_pkg::ACT_APPEND) && !drop_star && !store_full) begin
			store_q[wr_idx] <= symbol_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && (action_s1 == wpm_pkg::ACT_END)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && (action_s1 == wpm_pkg::ACT_END)) begin
			matched_q  <= !ovf_q && reach_q[len_q];
			overflow_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign overflow  = overflow_q;

endmodule

`default_nettype wire

// ===== rtl/wpm_checker.sv =====
`default_nettype none

module wpm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] action,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       matched,
	input wire logic       overflow
);

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(matched) && $stable(overflow))
		else $error("stalled result changed");

	// An overflowed pattern never reports a match.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && overflow))
		else $error("match reported with overflow");

	// The input side only waits behind a blocked result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with a free output");

	// A new result rises only after an accepted end transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			$past(in_valid && !in_stall && (action == wpm_pkg::ACT_END), 2))
		else $error("result without an end transaction");

endmodule

bind wildcard_pattern_matcher_top wpm_checker u_wpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.action    (action),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.matched   (matched),
	.overflow  (overflow)
);

`default_nettype wire

// ===== dv/tb_wildcard_pattern_matcher_top.sv =====
`timescale 1ns / 1ps

module tb_wildcard_pattern_matcher_top;

	localparam int RANDOM_ITEMS = 1050;
	localparam int CALM_ITEMS   = 100;
	localparam int CALM_RESULTS = 25;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int REPORT_MAX   = 10;

	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_C = 8'h63;

	typedef struct packed {
		wpm_pkg::action_t act;
		logic [7:0]       sym;
	} request_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [1:0] action    = wpm_pkg::ACT_CLEAR;
	logic [7:0] symbol    = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       matched;
	logic       overflow;

	// Stimulus queue and expected verdicts.
	request_t pending[$];
	verdict_t verdicts_due[$];

	// Predicted matcher state.
	logic [7:0]                      pat_bytes [wpm_pkg::PATTERN_DEPTH];
	logic [wpm_pkg::LEN_W-1:0]       pat_len      = '0;
	logic [wpm_pkg::PATTERN_DEPTH:0] live_pos     = (wpm_pkg::PATTERN_DEPTH+1)'(1);
	logic                            pat_overflow = 1'b0;

	int total_items    = 0;
	int end_total      = 0;
	int items_accepted = 0;
	int results_seen   = 0;
	int matches_seen   = 0;
	int overflow_seen  = 0;
	int error_count    = 0;
	int idle_left      = 0;
	int stall_left     = 0;
	int cycle_count    = 0;

	wildcard_pattern_matcher_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.matched   (matched),
		.overflow  (overflow)
	);

	// Clock generation.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Adds the next position after every reachable star; stars are in ascending
	// order, so a run of them propagates in a single pass.
	function automatic logic [wpm_pkg::PATTERN_DEPTH:0] close_stars(
			logic [wpm_pkg::PATTERN_DEPTH:0] set);
		for (int p = 0; p < wpm_pkg::PATTERN_DEPTH; p++) begin
			if (p < int'(pat_len) && set[p] && pat_bytes[p] == wpm_pkg::SYM_STAR)
				set[p + 1] = 1'b1;
		end
		return set;
	endfunction

	// Moves the reachable set over one text byte.
	function automatic logic [wpm_pkg::PATTERN_DEPTH:0] advance_over(logic [7:0] c);
		logic [wpm_pkg::PATTERN_DEPTH:0] nxt;
		nxt = '0;
		for (int p = 0; p < wpm_pkg::PATTERN_DEPTH; p++) begin
			if (p < int'(pat_len) && live_pos[p]) begin
				if (pat_bytes[p] == wpm_pkg::SYM_STAR)
					nxt[p] = 1'b1;
				else if (pat_bytes[p] == wpm_pkg::SYM_ANY || pat_bytes[p] == c)
					nxt[p + 1] = 1'b1;
			end
		end
		return close_stars(nxt);
	endfunction

	// Updates the predicted state for one accepted transaction and records the
	// verdict that an end of text must produce.
	task automatic predict_item(request_t r);
		logic     dup_star;
		verdict_t v;
		case (r.act)
			wpm_pkg::ACT_CLEAR: begin
				pat_len      = '0;
				pat_overflow = 1'b0;
				live_pos     = close_stars((wpm_pkg::PATTERN_DEPTH+1)'(1));
			end
			wpm_pkg::ACT_APPEND: begin
				// A star directly after a stored star is dropped without effect.
				dup_star = r.sym == wpm_pkg::SYM_STAR && pat_len != 0 &&
					pat_bytes[pat_len - 1'b1] == wpm_pkg::SYM_STAR;
				if (!dup_star) begin
					if (int'(pat_len) >= wpm_pkg::PATTERN_DEPTH) begin
						pat_overflow = 1'b1;
					end else begin
						pat_bytes[pat_len] = r.sym;
						pat_len            = pat_len + 1'b1;
						live_pos           = close_stars((wpm_pkg::PATTERN_DEPTH+1)'(1));
					end
				end
			end
			wpm_pkg::ACT_TEXT: begin
				live_pos = advance_over(r.sym);
			end
			default: begin
				v.matched    = pat_overflow ? 1'b0 : live_pos[pat_len];
				v.overflow   = pat_overflow;
				verdicts_due = {verdicts_due, v};
				live_pos     = close_stars((wpm_pkg::PATTERN_DEPTH+1)'(1));
			end
		endcase
	endtask

	task automatic note_error(string what);
		error_count++;
		if (error_count <= REPORT_MAX)
			$display("[%0t] %s", $realtime, what);
	endtask

	task automatic push_item(wpm_pkg::action_t a, logic [7:0] s);
		request_t r;
		r.act   = a;
		r.sym   = s;
		pending = {pending, r};
		if (a == wpm_pkg::ACT_END)
			end_total++;
	endtask

	function automatic logic [7:0] pattern_byte(bit long_form);
		int pick;
		pick = $urandom_range(0, 99);
		if (long_form) begin
			if (pick < 8)
				return wpm_pkg::SYM_STAR;
			else if (pick < 30)
				return wpm_pkg::SYM_ANY;
			else if (pick < 60)
				return CH_A;
			else if (pick < 85)
				return CH_B;
			return 8'($urandom);
		end
		if (pick < 25)
			return wpm_pkg::SYM_STAR;
		else if (pick < 45)
			return wpm_pkg::SYM_ANY;
		else if (pick < 70)
			return CH_A;
		else if (pick < 90)
			return CH_B;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] text_byte();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return CH_A;
		else if (pick < 7)
			return CH_B;
		return 8'($urandom);
	endfunction

	// Input driver: holds a stalled transaction, otherwise idles in bursts or
	// presents the next pending one.
	always @(posedge clk or negedge arst_n) begin : driver
		request_t req;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			action    <= wpm_pkg::ACT_CLEAR;
			symbol    <= 8'h00;
			idle_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				req.act = wpm_pkg::action_t'(action);
				req.sym = symbol;
				predict_item(req);
				items_accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (idle_left != 0) begin
					idle_left <= idle_left - 1;
					in_valid  <= 1'b0;
				end else if (pending.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
					idle_left <= $urandom_range(0, 7);
					in_valid  <= 1'b0;
				end else if (pending.size() != 0) begin
					req = pending.pop_front();
					in_valid <= 1'b1;
					action   <= req.act;
					symbol   <= req.sym;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted result against the oldest expected
	// verdict and drives stall bursts.
	always @(posedge clk or negedge arst_n) begin : monitor
		verdict_t want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (matched)
					matches_seen++;
				if (overflow)
					overflow_seen++;
				if (verdicts_due.size() == 0) begin
					note_error($sformatf("Unexpected result: matched=%0b overflow=%0b",
						matched, overflow));
				end else begin
					want = verdicts_due.pop_front();
					if (matched !== want.matched || overflow !== want.overflow)
						note_error($sformatf({"Mismatch on result %0d: ",
							"expected matched=%0b overflow=%0b, ",
							"got matched=%0b overflow=%0b"},
							results_seen, want.matched, want.overflow,
							matched, overflow));
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else if (results_seen + CALM_RESULTS < end_total &&
					$urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 7);
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles.", cycle_count);
		$display("RESULT: ERROR");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		logic [7:0] pat[$];
		logic [7:0] text[$];
		int         plen;
		int         pick;
		int         kind;

		// Directed part: empty pattern and empty text, stars, repeated stars,
		// the any-byte wildcard, extreme byte values and a pattern edited
		// while a text is in progress.
		push_item(wpm_pkg::ACT_END, 8'hFF);
		push_item(wpm_pkg::ACT_TEXT, 8'h00);
		push_item(wpm_pkg::ACT_END, 8'h00);
		push_item(wpm_pkg::ACT_APPEND, wpm_pkg::SYM_STAR);
		push_item(wpm_pkg::ACT_END, 8'h00);
		push_item(wpm_pkg::ACT_APPEND, wpm_pkg::SYM_STAR);
		push_item(wpm_pkg::ACT_TEXT, 8'hFF);
		push_item(wpm_pkg::ACT_END, 8'hFF);
		push_item(wpm_pkg::ACT_CLEAR, 8'hFF);
		push_item(wpm_pkg::ACT_APPEND, CH_A);
		push_item(wpm_pkg::ACT_APPEND, wpm_pkg::SYM_ANY);
		push_item(wpm_pkg::ACT_TEXT, CH_A);
		push_item(wpm_pkg::ACT_TEXT, 8'h00);
		push_item(wpm_pkg::ACT_END, 8'h00);
		push_item(wpm_pkg::ACT_TEXT, CH_A);
		push_item(wpm_pkg::ACT_END, 8'h00);
		push_item(wpm_pkg::ACT_TEXT, CH_A);
		push_item(wpm_pkg::ACT_APPEND, wpm_pkg::SYM_STAR);
		push_item(wpm_pkg::ACT_TEXT, CH_A);
		push_item(wpm_pkg::ACT_TEXT, CH_B);
		push_item(wpm_pkg::ACT_TEXT, CH_C);
		push_item(wpm_pkg::ACT_END, 8'h00);
		push_item(wpm_pkg::ACT_APPEND, 8'hFF);
		push_item(wpm_pkg::ACT_TEXT, 8'hFF);
		push_item(wpm_pkg::ACT_END, 8'hFF);

		// Random part: mostly a pattern followed by a few texts, many of them
		// built to match, with occasional overflowing patterns and noise.
		while (pending.size() < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				plen = $urandom_range(wpm_pkg::PATTERN_DEPTH + 1, wpm_pkg::PATTERN_DEPTH + 4);
			else if (pick < 14)
				plen = $urandom_range(12, wpm_pkg::PATTERN_DEPTH);
			else
				plen = $urandom_range(0, 6);
			pat.delete();
			push_item(wpm_pkg::ACT_CLEAR, 8'($urandom));
			repeat (plen) begin
				pat = {pat, pattern_byte(plen > 12)};
				push_item(wpm_pkg::ACT_APPEND, pat[$]);
			end
			repeat ($urandom_range(1, 4)) begin
				kind = $urandom_range(0, 99);
				text.delete();
				if (kind < 75) begin
					foreach (pat[i]) begin
						if (pat[i] == wpm_pkg::SYM_STAR) begin
							repeat ($urandom_range(0, 3))
								text = {text, text_byte()};
						end else if (pat[i] == wpm_pkg::SYM_ANY) begin
							text = {text, 8'($urandom)};
						end else begin
							text = {text, pat[i]};
						end
					end
					// Corrupt one byte so that near misses are exercised.
					if (kind >= 55) begin
						if (text.size() == 0)
							text = {text, text_byte()};
						else
							text[$urandom_range(0, text.size() - 1)] = text_byte();
					end
				end else if (kind < 90) begin
					repeat ($urandom_range(0, 8))
						text = {text, text_byte()};
				end else begin
					repeat ($urandom_range(1, 3))
						push_item(wpm_pkg::action_t'($urandom_range(0, 3)), 8'($urandom));
				end
				foreach (text[i])
					push_item(wpm_pkg::ACT_TEXT, text[i]);
				push_item(wpm_pkg::ACT_END, 8'($urandom));
			end
		end
		total_items = pending.size();

		// Reset.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain.
		while (items_accepted != total_items)
			@(negedge clk);
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d transactions and %0d end-of-text results",
			items_accepted, results_seen);
		$display("(%0d matched, %0d overflowed); errors found: %0d.",
			matches_seen, overflow_seen, error_count);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
